>>> rtl/pvct_pkg.sv
// shared widths and constants for the paravirtual clock tick generator
// no dependencies; imported by every module of the block
`default_nettype none

package pvct_pkg;

    // field widths
    localparam int TIME_W  = 64;
    localparam int FRAC_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int TICK_W  = 30;
    localparam int COUNT_W = 32;

    // tick length after reset: 100 Hz kernel clock
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10000000);

    // saturation value of the reported tick count
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

>>> rtl/pvct_scale.sv
// counter delta scaling: pre-shift, then delta times 0.32 fraction, top 64 bits
// one 32x32 multiplier used twice under a small sequencer; uses pvct_pkg
`default_nettype none

module pvct_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pvct_pkg::TIME_W-1:0]  i_delta,
    input  logic [pvct_pkg::FRAC_W-1:0]  i_frac,
    input  logic [pvct_pkg::SHIFT_W-1:0] i_shift,
    output logic                         o_done,
    output logic [pvct_pkg::TIME_W-1:0]  o_scaled
);
    import pvct_pkg::*;

    typedef enum logic [4:0] {
        SC_IDLE  = 5'b00001,
        SC_SHIFT = 5'b00010,
        SC_MLO   = 5'b00100,
        SC_MHI   = 5'b01000,
        SC_ADD   = 5'b10000
    } t_sc_state;

    t_sc_state            r_state;
    logic                 r_done;
    logic [TIME_W-1:0]    r_d;
    logic [FRAC_W-1:0]    r_frac;
    logic [SHIFT_W-1:0]   r_sh;
    logic [TIME_W-1:0]    r_prod;
    logic [FRAC_W-1:0]    r_plo_hi;
    logic [TIME_W-1:0]    r_scaled;

    logic [SHIFT_W:0]     w_rsh_amt;
    logic [TIME_W-1:0]    w_shifted;
    logic [FRAC_W-1:0]    w_mul_a;
    logic [TIME_W-1:0]    w_prod;

    // a set top bit means a right shift by 64 minus the code (1..32)
    assign w_rsh_amt = 7'd64 - {1'b0, r_sh};
    assign w_shifted = r_sh[SHIFT_W-1] ? (r_d >> w_rsh_amt) : (r_d << r_sh[SHIFT_W-2:0]);

    // shared multiplier: low half first, then high half
    assign w_mul_a = (r_state == SC_MLO) ? r_d[FRAC_W-1:0] : r_d[TIME_W-1:FRAC_W];
    assign w_prod  = {{(TIME_W-FRAC_W){1'b0}}, w_mul_a} * {{(TIME_W-FRAC_W){1'b0}}, r_frac};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_d     <= i_delta;
                        r_frac  <= i_frac;
                        r_sh    <= i_shift;
                        r_state <= SC_SHIFT;
                    end
                end
                SC_SHIFT: begin
                    r_d     <= w_shifted;
                    r_state <= SC_MLO;
                end
                SC_MLO: begin
                    r_prod  <= w_prod;
                    r_state <= SC_MHI;
                end
                SC_MHI: begin
                    r_plo_hi <= r_prod[TIME_W-1:FRAC_W];
                    r_prod   <= w_prod;
                    r_state  <= SC_ADD;
                end
                SC_ADD: begin
                    r_scaled <= r_prod + {{(TIME_W-FRAC_W){1'b0}}, r_plo_hi};
                    r_done   <= 1'b1;
                    r_state  <= SC_IDLE;
                end
                default: begin
                    r_state <= SC_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_scaled = r_scaled;

endmodule

`default_nettype wire

>>> rtl/pvct_div.sv
// restoring divider, one quotient bit per cycle: 64-bit dividend by tick length
// uses pvct_pkg for widths
`default_nettype none

module pvct_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pvct_pkg::TIME_W-1:0] i_dividend,
    input  logic [pvct_pkg::TICK_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [pvct_pkg::TIME_W-1:0] o_quotient,
    output logic [pvct_pkg::TICK_W-1:0] o_remainder
);
    import pvct_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_W-1:0]    r_quo;
    logic [TICK_W-1:0]    r_rem;
    logic [TICK_W-1:0]    r_div;

    logic [TICK_W:0]      w_trial;
    logic                 w_fits;
    logic [TICK_W:0]      w_diff;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_quo[TIME_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[TICK_W-1:0] : w_trial[TICK_W-1:0];
                r_quo <= {r_quo[TIME_W-2:0], w_fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TIME_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> rtl/pv_clock_tick_generator.sv
// paravirtual clock tick generator: snapshot scaling and kernel tick counting
// instantiates pvct_scale and pvct_div; uses pvct_pkg
// steps: scaler, sum, difference, then the divider for a timer item, while an
//   init item or a negative difference goes straight to the done step
// throughput: one item at a time; the next item is taken once the result is
//   in the output register, even while that result waits to be taken
// reset (synchronous, active low): idle, no result, tick length 10000000 ns,
//   processed time zero
`default_nettype none

module pv_clock_tick_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pvct_pkg::TICK_W-1:0]         i_cfg_wdata,
    // input item
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [pvct_pkg::TIME_W-1:0]         i_counter_now,
    input  logic [pvct_pkg::TIME_W-1:0]         i_stamp_count,
    input  logic [pvct_pkg::TIME_W-1:0]         i_stamp_time_ns,
    input  logic [pvct_pkg::FRAC_W-1:0]         i_mul_fraction,
    input  logic signed [pvct_pkg::SHIFT_W-1:0] i_scale_shift,
    // result item
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pvct_pkg::TIME_W-1:0]         o_system_time_ns,
    output logic [pvct_pkg::COUNT_W-1:0]        o_tick_count,
    output logic                                o_rearm,
    output logic [pvct_pkg::TIME_W-1:0]         o_deadline_ns,
    output logic signed [pvct_pkg::TIME_W-1:0]  o_leftover_ns
);
    import pvct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCALE = 6'b000010,
        S_SUM   = 6'b000100,
        S_DIFF  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state;
    logic [TICK_W-1:0]    r_tick;
    logic [TIME_W-1:0]    r_done_time;
    logic                 r_func;
    logic [TIME_W-1:0]    r_stamp_time;
    logic [TIME_W-1:0]    r_sys;
    logic [TIME_W-1:0]    r_diff;
    logic [COUNT_W-1:0]   r_count;
    logic [TIME_W-1:0]    r_left;
    logic                 r_div_start;
    logic                 r_out_valid;
    logic [TIME_W-1:0]    r_out_sys;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_rearm;
    logic [TIME_W-1:0]    r_out_deadline;
    logic [TIME_W-1:0]    r_out_left;

    logic                 w_in_accept;
    logic                 w_slot_free;
    logic [TICK_W-1:0]    w_tick;
    logic [TIME_W-1:0]    w_delta;
    logic                 w_scale_done;
    logic [TIME_W-1:0]    w_scaled;
    logic                 w_div_done;
    logic [TIME_W-1:0]    w_quo;
    logic [TICK_W-1:0]    w_rem;
    logic [TIME_W-1:0]    w_rem_ext;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);

    // a zero tick length counts as one
    assign w_tick    = (r_tick == '0) ? TICK_W'(1) : r_tick;
    assign w_delta   = i_counter_now - i_stamp_count;
    assign w_rem_ext = {{(TIME_W-TICK_W){1'b0}}, w_rem};

    // tick length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= TICK_RESET;
        end else if (i_cfg_we) begin
            r_tick <= i_cfg_wdata;
        end
    end

    pvct_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in_accept),
        .i_delta  (w_delta),
        .i_frac   (i_mul_fraction),
        .i_shift  (i_scale_shift),
        .o_done   (w_scale_done),
        .o_scaled (w_scaled)
    );

    pvct_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_diff),
        .i_divisor   (w_tick),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // item sequencer and processed-time state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_time <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_func       <= i_func;
                        r_stamp_time <= i_stamp_time_ns;
                        r_state      <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (w_scale_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sys   <= r_stamp_time + w_scaled;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_count <= '0;
                    if (!r_func) begin
                        r_done_time <= r_stamp_time;
                        r_left      <= '0;
                        r_state     <= S_DONE;
                    end else if (r_sys[TIME_W-1] != r_done_time[TIME_W-1] &&
                                 (r_sys - r_done_time) >= 64'h8000_0000_0000_0000) begin
                        // negative difference: no ticks
                        r_left  <= r_sys - r_done_time;
                        r_state <= S_DONE;
                    end else if ((r_sys - r_done_time) >= 64'h8000_0000_0000_0000) begin
                        r_left  <= r_sys - r_done_time;
                        r_state <= S_DONE;
                    end else begin
                        r_diff      <= r_sys - r_done_time;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_count     <= (w_quo[TIME_W-1:COUNT_W] != '0) ? COUNT_MAX
                                                                        : w_quo[COUNT_W-1:0];
                        r_left      <= w_rem_ext;
                        r_done_time <= r_sys - w_rem_ext;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid    <= 1'b1;
                r_out_sys      <= r_sys;
                r_out_count    <= r_count;
                r_out_rearm    <= (r_count != '0);
                r_out_deadline <= r_done_time + {{(TIME_W-TICK_W){1'b0}}, w_tick};
                r_out_left     <= r_left;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_system_time_ns = r_out_sys;
    assign o_tick_count     = r_out_count;
    assign o_rearm          = r_out_rearm;
    assign o_deadline_ns    = r_out_deadline;
    assign o_leftover_ns    = r_out_left;

    // the block takes no second item while one is in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // the re-arm flag follows the tick count
    a_rearm_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rearm == (r_out_count != '0)))
        else $error("re-arm flag disagrees with tick count");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    // after ticks are taken the remainder is below one tick
    a_left_below_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_done) |-> (w_rem < w_tick))
        else $error("remainder not below tick length");

    // a result is shown only after the sequencer finishes an item
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without a finished item");

endmodule

`default_nettype wire
